// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/ple_pkg.sv -----
package ple_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int WORD_W    = 32;
   localparam int POS_W     = 8;
   localparam int LEN_W     = 7;
   localparam int ACT_W     = 3;
   localparam int ST_W      = 3;

   localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [LEN_W-1:0]         where;
      logic [ST_W-1:0]          status;
      logic [LEN_W-1:0]         length;
      logic                     last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_APPEND = 3'd1,
      CELL_INSERT = 3'd2,
      CELL_DELETE = 3'd3,
      CELL_MATCH  = 3'd4,
      CELL_PICK   = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [POS_W-1:0]  slot;
      logic [WORD_W-1:0] key;
   } cell_ctrl_type;

endpackage

// ----- src/ple_stream_if.sv -----
interface ple_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/ple_cell.sv -----
module ple_cell import ple_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [WORD_W-1:0] prev_word,
   input  logic [WORD_W-1:0] next_word,
   input  logic              pick,
   output logic [WORD_W-1:0] word,
   output logic [WORD_W-1:0] rd_word,
   output logic              hit
);
   localparam logic [POS_W-1:0] MY_SLOT = POS_W'(IDX);

   logic [WORD_W-1:0] entry_ff, entry_in;
   logic              hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      unique case (ctrl.op)
         CELL_APPEND: begin
            if (ctrl.slot == MY_SLOT) entry_in = ctrl.key;
         end
         CELL_INSERT: begin
            if (MY_SLOT > ctrl.slot) entry_in = prev_word;
            else if (MY_SLOT == ctrl.slot) entry_in = ctrl.key;
         end
         CELL_DELETE: begin
            if (MY_SLOT >= ctrl.slot) entry_in = next_word;
         end
         CELL_MATCH: begin
            hit_in = (MY_SLOT < ctrl.slot) && (entry_ff == ctrl.key);
         end
         CELL_PICK: begin
            if (pick) hit_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign word    = entry_ff;
   assign rd_word = (ctrl.slot == MY_SLOT) ? entry_ff : '0;
   assign hit     = hit_ff;
endmodule

// ----- src/ple_scan.sv -----
module ple_scan import ple_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic [DEPTH-1:0]         hits,
   output logic [DEPTH-1:0]         pick,
   output logic [$clog2(DEPTH)-1:0] pick_idx,
   output logic                     any,
   output logic                     single
);
   localparam int IW = $clog2(DEPTH);

   // lowest set flag
   assign pick   = hits & (~hits + DEPTH'(1));
   assign any    = |hits;
   assign single = ((hits & ~pick) == '0);

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pick[i]) pick_idx = pick_idx | IW'(i);
      end
   end
endmodule

// ----- src/positional_list_engine_unit.sv -----
// Channel  Dir  Payload                                  Handshake
// req_ch   in   action[3] position[8] value[32]          valid/ready
// rsp_ch   out  data[32] where[7] status[3] length[7] last  valid/ready
//
// Append, insert, delete, get, clear and unused codes: append loads one cell,
// insert and delete shift cells from the position up, in the cycle taken.
// Locate: cells in the list flag matches first, then the match scan gives one
// result per cycle while the output is free, or one not-found result.
// Synchronous reset empties the list and drops any pending result.
// A stalled result holds the output register; no new item is taken until it
// can move.
`include "assert_macros.svh"

module positional_list_engine_unit import ple_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic          clock,
   input logic          reset,
   ple_stream_if.sink   req_ch,
   ple_stream_if.source rsp_ch
);
   localparam int IW = $clog2(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_pay_ff, rsp_pay_in;
   rsp_payload_type   result;
   cell_ctrl_type     ctrl;

   logic [WORD_W-1:0] cell_word [DEPTH];
   logic [WORD_W-1:0] cell_rd   [DEPTH];
   logic [DEPTH-1:0]  hits;
   logic [DEPTH-1:0]  pick;
   logic [IW-1:0]     pick_idx;
   logic              any_hit;
   logic              single_hit;
   logic [WORD_W-1:0] rd_bus;

   logic              out_free;
   logic              req_fire;
   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  pos_m1;
   logic [POS_W-1:0]  cnt8;
   logic              full;
   logic              bad_rd;
   logic              bad_ins;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      ple_cell #(.IDX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_word ((g == 0) ? cell_word[g] : cell_word[(g == 0) ? 0 : g - 1]),
         .next_word ((g == DEPTH - 1) ? cell_word[g]
                                      : cell_word[(g == DEPTH - 1) ? g : g + 1]),
         .pick      (pick[g]),
         .word      (cell_word[g]),
         .rd_word   (cell_rd[g]),
         .hit       (hits[g])
      );
   end

   ple_scan #(.DEPTH(DEPTH)) u_scan (
      .hits     (hits),
      .pick     (pick),
      .pick_idx (pick_idx),
      .any      (any_hit),
      .single   (single_hit)
   );

   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_bus = rd_bus | cell_rd[i];
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_pay_ff;

   assign pos     = req_ch.payload.position;
   assign pos_m1  = pos - POS_W'(1);
   assign cnt8    = POS_W'(count_ff);
   assign full    = count_ff >= LEN_W'(DEPTH);
   assign bad_rd  = (pos == '0) || (pos > cnt8);
   assign bad_ins = (pos == '0) || (pos > cnt8 + POS_W'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pay_in   = rsp_pay_ff;
      result       = '0;
      result.last  = 1'b1;
      result.status = ST_OK;
      ctrl.op      = CELL_HOLD;
      ctrl.slot    = pos_m1;
      ctrl.key     = req_ch.payload.value;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.payload.action)
                  ACT_APPEND: begin
                     if (full) begin
                        result.status = ST_FULL;
                     end else begin
                        ctrl.op   = CELL_APPEND;
                        ctrl.slot = cnt8;
                        count_in  = count_ff + LEN_W'(1);
                     end
                  end
                  ACT_INSERT: begin
                     if (bad_ins) begin
                        result.status = ST_BADPOS;
                     end else if (full) begin
                        result.status = ST_FULL;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + LEN_W'(1);
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        result.status = ST_EMPTY;
                     end else if (bad_rd) begin
                        result.status = ST_BADPOS;
                     end else begin
                        ctrl.op     = CELL_DELETE;
                        result.data = rd_bus;
                        count_in    = count_ff - LEN_W'(1);
                     end
                  end
                  ACT_GET: begin
                     if (bad_rd) result.status = ST_BADPOS;
                     else        result.data   = rd_bus;
                  end
                  ACT_LOCATE: begin
                     ctrl.op   = CELL_MATCH;
                     ctrl.slot = cnt8;
                     key_in    = req_ch.payload.value;
                     state_in  = S_SCAN;
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: ;
               endcase
               if (req_ch.payload.action != ACT_LOCATE) begin
                  result.length = count_in;
                  rsp_valid_in  = 1'b1;
                  rsp_pay_in    = result;
               end
            end
         end
         S_SCAN: begin
            if (out_free) begin
               if (!any_hit) begin
                  result.status = ST_NOTFOUND;
                  state_in      = S_IDLE;
               end else begin
                  result.data  = key_ff;
                  result.where = LEN_W'(pick_idx) + LEN_W'(1);
                  result.last  = single_hit;
                  ctrl.op      = CELL_PICK;
                  if (single_hit) state_in = S_IDLE;
               end
               result.length = count_ff;
               rsp_valid_in  = 1'b1;
               rsp_pay_in    = result;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= LEN_W'(DEPTH))
   `ASSERT_IMPLIES(a_no_take_in_scan, clock, reset, state_ff == S_SCAN, !req_ch.ready)
   `ASSERT_IMPLIES(a_idle_no_hits, clock, reset, state_ff == S_IDLE, hits == '0)
   `ASSERT_ALWAYS(a_pick_onehot, clock, reset, $onehot0(pick))
   `ASSERT_NEXT(a_locate_enters_scan, clock, reset, req_fire && req_ch.payload.action == ACT_LOCATE, state_ff == S_SCAN)
endmodule

// ----- tb/positional_list_engine_unit_tb.sv -----
module positional_list_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;

   localparam int DEPTH      = DEPTH_DEF;
   localparam int CLK_PERIOD = 20;
   localparam int RANDOM_OPS = 12;
   localparam int PRINT_CAP  = 100;

   // codes the block ignores
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_SPARSE,
      DRAIN_MOSTLY
   } drain_mode_type;

   logic clock;
   logic reset;

   ple_stream_if #(.payload_type(req_payload_type)) req_if ();
   ple_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   positional_list_engine_unit #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // list shadow and pending answers
   logic signed [WORD_W-1:0] model_words [DEPTH];
   int                       model_len;
   rsp_payload_type          list_answer_q [$];

   int error_count;
   int item_count;
   int result_count;
   int longest_match_run;
   int action_tally [8];
   int burst_left;

   drain_mode_type drain_mode;
   int             drain_tick;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void push_answer(input logic signed [WORD_W-1:0] data, input int where,
                                       input logic [ST_W-1:0] status, input bit last);
      rsp_payload_type r;
      r.data   = data;
      r.where  = where[LEN_W-1:0];
      r.status = status;
      r.length = model_len[LEN_W-1:0];
      r.last   = last;
      list_answer_q.push_back(r);
   endfunction

   task automatic predict_list_step(input req_payload_type item);
      int                       pos;
      int                       hits;
      int                       final_hit;
      logic signed [WORD_W-1:0] removed;
      pos       = item.position;
      hits      = 0;
      final_hit = -1;
      case (item.action)
         ACT_APPEND: begin
            if (model_len >= DEPTH) begin
               push_answer(0, 0, ST_FULL, 1'b1);
            end else begin
               model_words[model_len] = item.value;
               model_len++;
               push_answer(0, 0, ST_OK, 1'b1);
            end
         end
         ACT_INSERT: begin
            if (pos < 1 || pos > model_len + 1) begin
               push_answer(0, 0, ST_BADPOS, 1'b1);
            end else if (model_len >= DEPTH) begin
               push_answer(0, 0, ST_FULL, 1'b1);
            end else begin
               for (int i = model_len; i >= pos; i--)
                  model_words[i] = model_words[i-1];
               model_words[pos-1] = item.value;
               model_len++;
               push_answer(0, 0, ST_OK, 1'b1);
            end
         end
         ACT_DELETE: begin
            if (model_len == 0) begin
               push_answer(0, 0, ST_EMPTY, 1'b1);
            end else if (pos < 1 || pos > model_len) begin
               push_answer(0, 0, ST_BADPOS, 1'b1);
            end else begin
               removed = model_words[pos-1];
               for (int i = pos - 1; i + 1 < model_len; i++)
                  model_words[i] = model_words[i+1];
               model_len--;
               push_answer(removed, 0, ST_OK, 1'b1);
            end
         end
         ACT_GET: begin
            if (pos < 1 || pos > model_len)
               push_answer(0, 0, ST_BADPOS, 1'b1);
            else
               push_answer(model_words[pos-1], 0, ST_OK, 1'b1);
         end
         ACT_LOCATE: begin
            for (int i = 0; i < model_len; i++) begin
               if (model_words[i] == item.value) begin
                  final_hit = i;
                  hits++;
               end
            end
            if (final_hit < 0) begin
               push_answer(0, 0, ST_NOTFOUND, 1'b1);
            end else begin
               for (int i = 0; i < model_len; i++)
                  if (model_words[i] == item.value)
                     push_answer(model_words[i], i + 1, ST_OK, i == final_hit);
            end
            if (hits > longest_match_run)
               longest_match_run = hits;
         end
         ACT_CLEAR: begin
            model_len = 0;
            push_answer(0, 0, ST_OK, 1'b1);
         end
         default: begin
            push_answer(0, 0, ST_OK, 1'b1);
         end
      endcase
   endtask

   // Drives one item, waits for its transfer, then maybe opens a gap.
   task automatic send_item(input logic [ACT_W-1:0] action, input int position,
                            input logic signed [WORD_W-1:0] value);
      req_payload_type item;
      int              gap;
      item.action   = action;
      item.position = position[POS_W-1:0];
      item.value    = value;
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      predict_list_step(item);
      item_count++;
      action_tally[action]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (drain_tick == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         drain_tick = $urandom_range(16, 80);
      end else begin
         drain_tick--;
      end
      case (drain_mode)
         DRAIN_FREE:   rsp_if.ready <= 1'b1;
         DRAIN_COIN:   rsp_if.ready <= ($urandom_range(0, 1) == 1);
         DRAIN_SPARSE: rsp_if.ready <= (drain_tick % 4 == 0);
         default:      rsp_if.ready <= ($urandom_range(0, 4) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         result_count++;
         if (list_answer_q.size() == 0) begin
            report_mismatch("result transfer with nothing pending, data", got.data, 0);
         end else begin
            want = list_answer_q.pop_front();
            if (got.data !== want.data)
               report_mismatch("data", got.data, want.data);
            if (got.where !== want.where)
               report_mismatch("where", got.where, want.where);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.length !== want.length)
               report_mismatch("length", got.length, want.length);
            if (got.last !== want.last)
               report_mismatch("last", got.last, want.last);
         end
      end
   end

   task automatic test_empty_list();
      send_item(ACT_GET, 1, 0);
      send_item(ACT_DELETE, 1, 0);
      send_item(ACT_DELETE, 0, 0);
      send_item(ACT_LOCATE, 0, 0);
      send_item(ACT_INSERT, 0, 5);
      send_item(ACT_INSERT, 2, 5);
      send_item(ACT_SPARE_LO, $urandom_range(0, 255), $urandom);
      send_item(ACT_SPARE_HI, 255, -1);
      send_item(ACT_INSERT, 1, {1'b1, {(WORD_W-1){1'b0}}});
   endtask

   task automatic test_edit_ops();
      send_item(ACT_APPEND, 255, {1'b0, {(WORD_W-1){1'b1}}});
      send_item(ACT_APPEND, 0, -1);
      send_item(ACT_INSERT, 4, 0);
      send_item(ACT_INSERT, 6, 7);
      send_item(ACT_INSERT, 255, 7);
      send_item(ACT_INSERT, 2, -1);
      send_item(ACT_GET, 1, 0);
      send_item(ACT_GET, 5, 0);
      send_item(ACT_GET, 6, 0);
      send_item(ACT_GET, 0, 0);
      send_item(ACT_GET, 255, 0);
      send_item(ACT_LOCATE, 0, -1);
      send_item(ACT_LOCATE, 0, 12345);
      send_item(ACT_DELETE, 0, 0);
      send_item(ACT_DELETE, 255, 0);
      send_item(ACT_DELETE, 3, 0);
      send_item(ACT_DELETE, 4, 0);
      send_item(ACT_CLEAR, 0, 0);
      send_item(ACT_GET, 1, 0);
   endtask

   task automatic test_full_list();
      logic signed [WORD_W-1:0] key;
      key = $urandom;
      for (int i = 0; i < DEPTH; i++) begin
         if ($urandom_range(0, 1) == 0)
            send_item(ACT_APPEND, $urandom_range(0, 255), key);
         else
            send_item(ACT_INSERT, $urandom_range(1, model_len + 1), key);
      end
      send_item(ACT_APPEND, 0, 1);
      send_item(ACT_INSERT, DEPTH + 1, 1);
      send_item(ACT_INSERT, DEPTH + 2, 1);
      send_item(ACT_INSERT, 1, 1);
      send_item(ACT_GET, DEPTH, 0);
      send_item(ACT_GET, DEPTH + 1, 0);
      send_item(ACT_LOCATE, 0, key);
      send_item(ACT_DELETE, DEPTH, 0);
      send_item(ACT_DELETE, 1, 0);
      send_item(ACT_INSERT, 1, ~key);
      send_item(ACT_LOCATE, 0, key);
      send_item(ACT_LOCATE, 0, ~key);
      send_item(ACT_CLEAR, 0, 0);
   endtask

   // Mostly in-range positions and keys from a small pool so locates hit.
   task automatic test_random_ops();
      logic signed [WORD_W-1:0] key_pool [8];
      logic signed [WORD_W-1:0] value;
      logic [ACT_W-1:0]         act;
      int                       pick;
      int                       pos;
      int                       counted;
      bit                       aimed;
      counted = 0;
      foreach (key_pool[k])
         key_pool[k] = $urandom;
      key_pool[0] = {1'b1, {(WORD_W-1){1'b0}}};
      key_pool[1] = {1'b0, {(WORD_W-1){1'b1}}};
      while (counted < RANDOM_OPS) begin
         pick  = $urandom_range(0, 99);
         aimed = ($urandom_range(0, 9) < 8);
         if ($urandom_range(0, 9) < 7)
            value = key_pool[$urandom_range(0, 7)];
         else
            value = $urandom;
         pos = $urandom_range(0, 255);
         if (pick < 24) begin
            act = ACT_APPEND;
         end else if (pick < 44) begin
            act = ACT_INSERT;
            if (aimed)
               pos = $urandom_range(1, model_len + 1);
         end else if (pick < 62) begin
            act = ACT_DELETE;
            if (aimed && model_len > 0)
               pos = $urandom_range(1, model_len);
         end else if (pick < 76) begin
            act = ACT_GET;
            if (aimed && model_len > 0)
               pos = $urandom_range(1, model_len);
         end else if (pick < 92) begin
            act = ACT_LOCATE;
         end else if (pick < 95) begin
            act = ACT_CLEAR;
         end else begin
            act = ($urandom_range(0, 1) == 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
         end
         counted++;
         send_item(act, pos, value);
      end
   endtask

   initial begin
      int drain_wait;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      drain_mode     = DRAIN_FREE;
      drain_tick     = 0;
      model_len      = 0;
      burst_left     = 0;
      error_count    = 0;
      item_count     = 0;
      result_count   = 0;
      longest_match_run = 0;
      foreach (action_tally[k])
         action_tally[k] = 0;
      foreach (model_words[k])
         model_words[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edit_ops();
      test_full_list();
      test_random_ops();
      req_if.valid <= 1'b0;

      drain_wait = 0;
      while (list_answer_q.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (list_answer_q.size() != 0)
         report_mismatch("result transfers never arrived, count", list_answer_q.size(), 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d request transfers: append %0d, insert %0d, delete %0d, get %0d,",
               item_count, action_tally[ACT_APPEND], action_tally[ACT_INSERT],
               action_tally[ACT_DELETE], action_tally[ACT_GET]);
      $display("  locate %0d, clear %0d, ignored codes %0d.",
               action_tally[ACT_LOCATE], action_tally[ACT_CLEAR],
               action_tally[ACT_SPARE_LO] + action_tally[ACT_SPARE_HI]);
      $display("Checked %0d result transfers; longest locate answer had %0d matches;",
               result_count, longest_match_run);
      $display("  %0d mismatches.", error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- positional_list_engine_unit.f -----
+incdir+src
src/ple_pkg.sv
src/ple_stream_if.sv
src/ple_cell.sv
src/ple_scan.sv
src/positional_list_engine_unit.sv
tb/positional_list_engine_unit_tb.sv
